// ----- hdl/ppc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppc_pkg: shared types and codes of the pair correlation block
// Field widths of the request and response words, request and status codes.
// ----------------------------------------------------------------------------
package ppc_pkg;

   // Fixed field widths of the channel words
   localparam int REQ_W    = 2;
   localparam int ENTRY_W  = 12;
   localparam int RATING_W = 4;
   localparam int MOVIE_W  = 12;
   localparam int CORR_W   = 16;
   localparam int STATUS_W = 3;
   localparam int PAIR_W   = 20;

   typedef logic [REQ_W-1:0]    req_code_type;
   typedef logic [STATUS_W-1:0] status_type;

   // Request codes
   localparam req_code_type REQ_CLEAR = 2'd0;
   localparam req_code_type REQ_ACCUM = 2'd1;
   localparam req_code_type REQ_READ  = 2'd2;

   // Response status codes
   localparam status_type STATUS_COMPUTED  = 3'd0;
   localparam status_type STATUS_DIAGONAL  = 3'd1;
   localparam status_type STATUS_EMPTY     = 3'd2;
   localparam status_type STATUS_ZERO_DEN  = 3'd3;
   localparam status_type STATUS_SATURATED = 3'd4;

   // Q1.15 constants
   localparam logic signed [CORR_W-1:0] CORR_ONE  = 16'sh7FFF;
   localparam logic signed [CORR_W-1:0] CORR_ZERO = 16'sh0000;

   // One response word
   typedef struct packed {
      logic [ENTRY_W-1:0]        entry_out;
      logic signed [CORR_W-1:0]  correlation;
      status_type                status;
      logic [PAIR_W-1:0]         pair_count;
   } rsp_word_type;

endpackage

// ----- hdl/ppc_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppc_if: request and response channels
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface ppc_req_if;
   logic                          valid;
   logic                          ready;
   logic [ppc_pkg::REQ_W-1:0]     req_type;
   logic [ppc_pkg::ENTRY_W-1:0]   req_entry;
   logic [ppc_pkg::RATING_W-1:0]  req_row_rating;
   logic [ppc_pkg::RATING_W-1:0]  req_partner_rating;
   logic [ppc_pkg::MOVIE_W-1:0]   req_row_movie;

   modport source (output valid, req_type, req_entry, req_row_rating,
                   req_partner_rating, req_row_movie, input ready);
   modport sink   (input valid, req_type, req_entry, req_row_rating,
                   req_partner_rating, req_row_movie, output ready);
endinterface

interface ppc_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [ppc_pkg::ENTRY_W-1:0]         rsp_entry_out;
   logic signed [ppc_pkg::CORR_W-1:0]   rsp_correlation;
   logic [ppc_pkg::STATUS_W-1:0]        rsp_status;
   logic [ppc_pkg::PAIR_W-1:0]          rsp_pair_count;

   modport source (output valid, rsp_entry_out, rsp_correlation, rsp_status,
                   rsp_pair_count, input ready);
   modport sink   (input valid, rsp_entry_out, rsp_correlation, rsp_status,
                   rsp_pair_count, output ready);
endinterface

// ----- hdl/ppc_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppc_ram: generic simple dual-port RAM
// One write port, one read port with registered data; a read at the address
// being written returns the old contents.
// ----------------------------------------------------------------------------
module ppc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and read in the same edge
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/ppc_corr_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppc_corr_unit: correlation sequencer
// Forms the two variances and the covariance with two shared multipliers,
// takes both floor square roots one bit pair a cycle and divides one
// quotient bit a cycle; rounds and clamps to Q1.15.
// ----------------------------------------------------------------------------
module ppc_corr_unit #(
   parameter int COUNT_BITS  = 20,
   parameter int RATING_BITS = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [ppc_pkg::ENTRY_W-1:0]         start_entry,
   input  logic                                start_diag,
   input  logic [COUNT_BITS-1:0]               sum_n,
   input  logic [COUNT_BITS+RATING_BITS-1:0]   sum_x,
   input  logic [COUNT_BITS+RATING_BITS-1:0]   sum_y,
   input  logic [COUNT_BITS+2*RATING_BITS-1:0] sum_xy,
   input  logic [COUNT_BITS+2*RATING_BITS-1:0] sum_xx,
   input  logic [COUNT_BITS+2*RATING_BITS-1:0] sum_yy,
   output logic                                idle,
   output logic                                out_valid,
   input  logic                                out_ready,
   output ppc_pkg::rsp_word_type               out_word
);

   localparam int SUM_BITS = COUNT_BITS + RATING_BITS;
   localparam int SQ_BITS  = COUNT_BITS + 2 * RATING_BITS;
   localparam int DW       = COUNT_BITS + SQ_BITS;
   localparam int RW       = DW / 2;
   localparam int QW       = 17;
   localparam int NW       = DW + QW + 1;
   localparam int CNT_W    = $clog2(DW + QW);
   localparam int PAIR_W   = ppc_pkg::PAIR_W;
   localparam int CORR_W   = ppc_pkg::CORR_W;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_MULX  = 4'd1;
   localparam logic [3:0] ST_MULY  = 4'd2;
   localparam logic [3:0] ST_MULXY = 4'd3;
   localparam logic [3:0] ST_DIFF  = 4'd4;
   localparam logic [3:0] ST_SQX   = 4'd5;
   localparam logic [3:0] ST_SQY   = 4'd6;
   localparam logic [3:0] ST_DEN   = 4'd7;
   localparam logic [3:0] ST_CHECK = 4'd8;
   localparam logic [3:0] ST_DIV   = 4'd9;
   localparam logic [3:0] ST_FIN   = 4'd10;
   localparam logic [3:0] ST_OUT   = 4'd11;

   logic [3:0]            state_ff, state_in;
   logic [COUNT_BITS-1:0] n_ff, n_in;
   logic [SUM_BITS-1:0]   x_ff, x_in, y_ff, y_in;
   logic [SQ_BITS-1:0]    xy_ff, xy_in, xx_ff, xx_in, yy_ff, yy_in;
   logic [DW-1:0]         p1_ff, p1_in, p2_ff, p2_in;
   logic [DW-1:0]         dx_ff, dx_in, dy_ff, dy_in, mag_ff, mag_in;
   logic                  neg_ff, neg_in;
   logic [DW-1:0]         sq_v_ff, sq_v_in, sq_root_ff, sq_root_in, sq_bit_ff, sq_bit_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [RW-1:0]         rx_ff, rx_in;
   logic [DW-1:0]         den_ff, den_in;
   logic [DW+1:0]         rem_ff, rem_in;
   logic [QW-1:0]         num_lo_ff, num_lo_in, q_ff, q_in;
   logic                  ovf_ff, ovf_in;
   ppc_pkg::rsp_word_type word_ff, word_in;

   logic [COUNT_BITS-1:0] m1a;
   logic [SQ_BITS-1:0]    m1b;
   logic [SUM_BITS-1:0]   m2a, m2b;
   logic [DW-1:0]         root_sum, root_step, v_step;
   logic                  root_take;
   logic [NW-1:0]         num_full, div_lim;
   logic [DW:0]           divisor;
   logic [DW+1:0]         rem_sh;
   logic [QW-1:0]         q_sat;
   logic [CORR_W-1:0]     q_clamp;

   // Operand selection for the two shared multipliers
   always_comb begin
      m1a = n_ff;
      m1b = xx_ff;
      m2a = x_ff;
      m2b = x_ff;
      case (state_ff)
         ST_MULY: begin
            m1b = yy_ff;
            m2a = y_ff;
            m2b = y_ff;
         end
         ST_MULXY: begin
            m1b = xy_ff;
            m2b = y_ff;
         end
         default: begin
         end
      endcase
   end

   // One step of the bit-pair square root
   assign root_sum  = sq_root_ff + sq_bit_ff;
   assign root_take = sq_v_ff >= root_sum;
   assign v_step    = root_take ? sq_v_ff - root_sum : sq_v_ff;
   assign root_step = root_take ? (sq_root_ff >> 1) + sq_bit_ff : sq_root_ff >> 1;

   // Rounded numerator, doubled divisor and the quotient limit
   assign num_full = (NW'(mag_ff) << 16) + NW'(den_ff);
   assign divisor  = {den_ff, 1'b0};
   assign div_lim  = NW'(divisor) << QW;
   assign rem_sh   = {rem_ff[DW:0], num_lo_ff[QW-1]};

   // Clamp the quotient to the Q1.15 range of its sign
   always_comb begin
      q_sat = ovf_ff ? {QW{1'b1}} : q_ff;
      if (neg_ff) begin
         q_clamp = (q_sat > QW'(32768)) ? 16'h8000 : q_sat[CORR_W-1:0];
      end else begin
         q_clamp = (q_sat > QW'(32767)) ? 16'h7FFF : q_sat[CORR_W-1:0];
      end
   end

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      n_in       = n_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      xy_in      = xy_ff;
      xx_in      = xx_ff;
      yy_in      = yy_ff;
      p1_in      = p1_ff;
      p2_in      = p2_ff;
      dx_in      = dx_ff;
      dy_in      = dy_ff;
      mag_in     = mag_ff;
      neg_in     = neg_ff;
      sq_v_in    = sq_v_ff;
      sq_root_in = sq_root_ff;
      sq_bit_in  = sq_bit_ff;
      cnt_in     = cnt_ff;
      rx_in      = rx_ff;
      den_in     = den_ff;
      rem_in     = rem_ff;
      num_lo_in  = num_lo_ff;
      q_in       = q_ff;
      ovf_in     = ovf_ff;
      word_in    = word_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               n_in  = sum_n;
               x_in  = sum_x;
               y_in  = sum_y;
               xy_in = sum_xy;
               xx_in = sum_xx;
               yy_in = sum_yy;
               word_in.entry_out   = start_entry;
               word_in.correlation = ppc_pkg::CORR_ZERO;
               word_in.pair_count  = PAIR_W'(sum_n);
               word_in.status      = ppc_pkg::STATUS_COMPUTED;
               if (start_diag) begin
                  word_in.correlation = ppc_pkg::CORR_ONE;
                  word_in.status      = ppc_pkg::STATUS_DIAGONAL;
                  state_in            = ST_OUT;
               end else if (sum_n == '0) begin
                  word_in.status = ppc_pkg::STATUS_EMPTY;
                  state_in       = ST_OUT;
               end else begin
                  state_in = ST_MULX;
               end
            end
         end
         ST_MULX, ST_MULY, ST_MULXY: begin
            p1_in = DW'(m1a) * DW'(m1b);
            p2_in = DW'(m2a) * DW'(m2b);
            if (state_ff == ST_MULY) begin
               dx_in = p1_ff - p2_ff;
            end
            if (state_ff == ST_MULXY) begin
               dy_in = p1_ff - p2_ff;
            end
            state_in = state_ff + 4'd1;
         end
         ST_DIFF: begin
            neg_in     = p2_ff > p1_ff;
            mag_in     = (p2_ff > p1_ff) ? p2_ff - p1_ff : p1_ff - p2_ff;
            sq_v_in    = dx_ff;
            sq_root_in = '0;
            sq_bit_in  = DW'(1) << (DW - 2);
            cnt_in     = '0;
            state_in   = ST_SQX;
         end
         ST_SQX, ST_SQY: begin
            sq_v_in    = v_step;
            sq_root_in = root_step;
            sq_bit_in  = sq_bit_ff >> 2;
            cnt_in     = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(RW - 1)) begin
               cnt_in = '0;
               if (state_ff == ST_SQX) begin
                  rx_in      = root_step[RW-1:0];
                  sq_v_in    = dy_ff;
                  sq_root_in = '0;
                  sq_bit_in  = DW'(1) << (DW - 2);
                  state_in   = ST_SQY;
               end else begin
                  state_in = ST_DEN;
               end
            end
         end
         ST_DEN: begin
            den_in   = DW'(rx_ff) * DW'(sq_root_ff[RW-1:0]);
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (den_ff == '0) begin
               word_in.status = ppc_pkg::STATUS_ZERO_DEN;
               state_in       = ST_OUT;
            end else begin
               ovf_in    = num_full >= div_lim;
               rem_in    = (DW+2)'(num_full >> QW);
               num_lo_in = num_full[QW-1:0];
               q_in      = '0;
               cnt_in    = '0;
               state_in  = (num_full >= div_lim) ? ST_FIN : ST_DIV;
            end
         end
         ST_DIV: begin
            if (rem_sh >= (DW+2)'(divisor)) begin
               rem_in = rem_sh - (DW+2)'(divisor);
               q_in   = {q_ff[QW-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               q_in   = {q_ff[QW-2:0], 1'b0};
            end
            num_lo_in = num_lo_ff << 1;
            cnt_in    = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(QW - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            word_in.correlation = neg_ff ? (16'd0 - q_clamp) : q_clamp;
            word_in.status      = ppc_pkg::STATUS_COMPUTED;
            state_in            = ST_OUT;
         end
         ST_OUT: begin
            if (out_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Advance the sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      n_ff       <= n_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      xy_ff      <= xy_in;
      xx_ff      <= xx_in;
      yy_ff      <= yy_in;
      p1_ff      <= p1_in;
      p2_ff      <= p2_in;
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      mag_ff     <= mag_in;
      neg_ff     <= neg_in;
      sq_v_ff    <= sq_v_in;
      sq_root_ff <= sq_root_in;
      sq_bit_ff  <= sq_bit_in;
      cnt_ff     <= cnt_in;
      rx_ff      <= rx_in;
      den_ff     <= den_in;
      rem_ff     <= rem_in;
      num_lo_ff  <= num_lo_in;
      q_ff       <= q_in;
      ovf_ff     <= ovf_in;
      word_ff    <= word_in;
   end

   assign idle      = state_ff == ST_IDLE;
   assign out_valid = state_ff == ST_OUT;
   assign out_word  = word_ff;

endmodule

// ----- hdl/pearson_pair_correlation_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pearson_pair_correlation_top: per-partner Pearson sums and coefficient
// Table of six sums per partner movie in one RAM, with a correlation reader.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries clear, accumulate and read words; rsp_chan returns one
//   word per read and per accumulate refused on a saturated count.
//   Clear and accumulate words are taken one per cycle unless a read or a
//   waiting refusal stalls; the RAM is read when a word is taken and written
//   back in the next cycle, the last write forwarded to a later word on that entry.
//   A read runs the bit-pair square root twice and the 17-step divider;
//   no word is taken while a read is in progress.
//   A refused accumulate is answered from stage one through the response register.
//   After reset a clearing pass writes zero into all MOVIES entries, one a
//   cycle, with req_chan.ready held low.
//   When rsp_chan stalls the response register holds its word, and the
//   block stops taking words once a further response would be needed.
// ----------------------------------------------------------------------------
module pearson_pair_correlation_top #(
   parameter int MOVIES      = 4096,
   parameter int COUNT_BITS  = 20,
   parameter int RATING_BITS = 4
) (
   input  logic       clock,
   input  logic       reset,
   ppc_req_if.sink    req_chan,
   ppc_rsp_if.source  rsp_chan
);

   localparam int SUM_BITS  = COUNT_BITS + RATING_BITS;
   localparam int SQ_BITS   = COUNT_BITS + 2 * RATING_BITS;
   localparam int PR_BITS   = 2 * RATING_BITS;
   localparam int WORD_BITS = COUNT_BITS + 2 * SUM_BITS + 3 * SQ_BITS;
   localparam int ADDR_BITS = $clog2(MOVIES);
   localparam int PAIR_W    = ppc_pkg::PAIR_W;
   localparam int ENTRY_W   = ppc_pkg::ENTRY_W;

   typedef struct packed {
      logic [COUNT_BITS-1:0] n;
      logic [SUM_BITS-1:0]   x;
      logic [SUM_BITS-1:0]   y;
      logic [SQ_BITS-1:0]    xy;
      logic [SQ_BITS-1:0]    xx;
      logic [SQ_BITS-1:0]    yy;
   } sums_type;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   // Clearing pass
   logic                 clr_busy_ff, clr_busy_in;
   logic [ADDR_BITS-1:0] clr_addr_ff, clr_addr_in;

   // Stage one: word whose RAM data arrives this cycle
   logic                         s1_valid_ff, s1_valid_in;
   ppc_pkg::req_code_type        s1_type_ff;
   logic [ENTRY_W-1:0]           s1_entry_ff;
   logic [RATING_BITS-1:0]       s1_a_ff, s1_b_ff;
   logic [ppc_pkg::MOVIE_W-1:0]  s1_row_ff;
   logic                         s1_inrange_ff;

   // Forwarding of the last write
   logic                 fwd_valid_ff, fwd_valid_in;
   logic [ADDR_BITS-1:0] fwd_addr_ff;
   sums_type             fwd_data_ff;

   // Response register
   logic                  rsp_valid_ff, rsp_valid_in;
   ppc_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   logic                 req_fire, out_free;
   logic [ADDR_BITS-1:0] req_addr, s1_addr, rd_addr, wr_addr;
   logic [WORD_BITS-1:0] rd_word;
   sums_type             ram_sums, cur, upd, wr_data;
   logic                 wr_en, s1_write;
   logic                 s1_is_accum, s1_sat, s1_is_read, s1_stall;
   logic [PR_BITS-1:0]   prod_ab, prod_aa, prod_bb;
   logic [COUNT_BITS-1:0] cur_n;
   logic                 corr_idle, corr_valid, corr_ready;
   ppc_pkg::rsp_word_type corr_word;

   assign req_addr = ADDR_BITS'(req_chan.req_entry);
   assign s1_addr  = ADDR_BITS'(s1_entry_ff);
   assign ram_sums = sums_type'(rd_word);
   assign cur      = (fwd_valid_ff && fwd_addr_ff == s1_addr) ? fwd_data_ff : ram_sums;
   assign cur_n    = s1_inrange_ff ? cur.n : '0;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // Stage one decisions
   assign s1_is_accum = s1_valid_ff && s1_type_ff == ppc_pkg::REQ_ACCUM && s1_inrange_ff;
   assign s1_sat      = s1_is_accum && cur.n == COUNT_MAX;
   assign s1_is_read  = s1_valid_ff && s1_type_ff == ppc_pkg::REQ_READ;
   assign s1_stall    = (s1_sat && !out_free) || (s1_is_read && !corr_idle);
   assign s1_write    = !s1_stall && s1_valid_ff && s1_inrange_ff &&
                        (s1_type_ff == ppc_pkg::REQ_CLEAR || (s1_is_accum && !s1_sat));

   assign req_chan.ready = !clr_busy_ff && corr_idle && !s1_stall && !s1_is_read;
   assign req_fire       = req_chan.valid && req_chan.ready;

   // Updated sums for one rating pair
   always_comb begin
      prod_ab = PR_BITS'(s1_a_ff) * PR_BITS'(s1_b_ff);
      prod_aa = PR_BITS'(s1_a_ff) * PR_BITS'(s1_a_ff);
      prod_bb = PR_BITS'(s1_b_ff) * PR_BITS'(s1_b_ff);
      upd.n   = cur.n + COUNT_BITS'(1);
      upd.x   = cur.x + SUM_BITS'(s1_a_ff);
      upd.y   = cur.y + SUM_BITS'(s1_b_ff);
      upd.xy  = cur.xy + SQ_BITS'(prod_ab);
      upd.xx  = cur.xx + SQ_BITS'(prod_aa);
      upd.yy  = cur.yy + SQ_BITS'(prod_bb);
   end

   // RAM port selection: clearing pass, then stage one write-back
   always_comb begin
      if (clr_busy_ff) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = '0;
      end else begin
         wr_en   = s1_write;
         wr_addr = s1_addr;
         wr_data = (s1_type_ff == ppc_pkg::REQ_CLEAR) ? sums_type'('0) : upd;
      end
      rd_addr = s1_stall ? s1_addr : req_addr;
   end

   ppc_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (MOVIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (WORD_BITS'(wr_data)),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   ppc_corr_unit #(
      .COUNT_BITS  (COUNT_BITS),
      .RATING_BITS (RATING_BITS)
   ) u_corr (
      .clock       (clock),
      .reset       (reset),
      .start       (s1_is_read && corr_idle),
      .start_entry (s1_entry_ff),
      .start_diag  (s1_entry_ff == s1_row_ff),
      .sum_n       (cur_n),
      .sum_x       (s1_inrange_ff ? cur.x : '0),
      .sum_y       (s1_inrange_ff ? cur.y : '0),
      .sum_xy      (s1_inrange_ff ? cur.xy : '0),
      .sum_xx      (s1_inrange_ff ? cur.xx : '0),
      .sum_yy      (s1_inrange_ff ? cur.yy : '0),
      .idle        (corr_idle),
      .out_valid   (corr_valid),
      .out_ready   (corr_ready),
      .out_word    (corr_word)
   );

   assign corr_ready = out_free && !s1_sat;

   // Next state of the control registers
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + ADDR_BITS'(1);
         if (clr_addr_ff == ADDR_BITS'(MOVIES - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
      s1_valid_in  = s1_stall ? s1_valid_ff : req_fire;
      fwd_valid_in = wr_en ? !clr_busy_ff : fwd_valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_word_in  = rsp_word_ff;
      if (s1_sat && out_free) begin
         rsp_valid_in            = 1'b1;
         rsp_word_in.entry_out   = s1_entry_ff;
         rsp_word_in.correlation = ppc_pkg::CORR_ZERO;
         rsp_word_in.status      = ppc_pkg::STATUS_SATURATED;
         rsp_word_in.pair_count  = PAIR_W'(cur.n);
      end else if (corr_valid && corr_ready) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = corr_word;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_busy_ff  <= clr_busy_in;
         clr_addr_ff  <= clr_addr_in;
         s1_valid_ff  <= s1_valid_in;
         fwd_valid_ff <= fwd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: capture taken words, hold on stall
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_type_ff    <= req_chan.req_type;
         s1_entry_ff   <= req_chan.req_entry;
         s1_a_ff       <= RATING_BITS'(req_chan.req_row_rating);
         s1_b_ff       <= RATING_BITS'(req_chan.req_partner_rating);
         s1_row_ff     <= req_chan.req_row_movie;
         s1_inrange_ff <= 32'(req_chan.req_entry) < MOVIES;
      end
      if (wr_en) begin
         fwd_addr_ff <= wr_addr;
         fwd_data_ff <= wr_data;
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.rsp_entry_out   = rsp_word_ff.entry_out;
   assign rsp_chan.rsp_correlation = rsp_word_ff.correlation;
   assign rsp_chan.rsp_status      = rsp_word_ff.status;
   assign rsp_chan.rsp_pair_count  = rsp_word_ff.pair_count;

endmodule

// ----- hdl/ppc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppc_checker: port-level checks of the response channel
// Watches the response words for handshake hold and coded value rules.
// ----------------------------------------------------------------------------
module ppc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [ppc_pkg::CORR_W-1:0] rsp_correlation,
   input logic [ppc_pkg::STATUS_W-1:0]      rsp_status,
   input logic [ppc_pkg::PAIR_W-1:0]        rsp_pair_count
);

   // Hold the correlation and status of a stalled response word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_correlation)
                                  && $stable(rsp_status))
      else $error("response word changed while stalled");

   // Diagonal reads give CORR_ONE, the largest Q1.15 value
   a_diag_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ppc_pkg::STATUS_DIAGONAL
      |-> rsp_correlation == ppc_pkg::CORR_ONE)
      else $error("diagonal response is not one");

   // Non-computed, non-diagonal responses carry zero
   a_zero_corr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ppc_pkg::STATUS_COMPUTED
      && rsp_status != ppc_pkg::STATUS_DIAGONAL
      |-> rsp_correlation == ppc_pkg::CORR_ZERO)
      else $error("nonzero correlation on a fault status");

   // Empty entries report a zero count
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ppc_pkg::STATUS_EMPTY |-> rsp_pair_count == '0)
      else $error("empty entry with nonzero count");

endmodule

bind pearson_pair_correlation_top ppc_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_correlation (rsp_chan.rsp_correlation),
   .rsp_status      (rsp_chan.rsp_status),
   .rsp_pair_count  (rsp_chan.rsp_pair_count)
);
